[rtl/kdpl_pkg.sv]
// ----------------------------------------------------------------------------
// kdpl_pkg
// Shared types and constants for the key debounce and press length classifier.
// ----------------------------------------------------------------------------
package kdpl_pkg;

    localparam int NUM_KEYS_DEF = 3;
    localparam int HOLD_W       = 16;
    localparam int INC_W        = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HOLD_W-1:0] SHORT_THR_RESET = 16'd1000;
    localparam logic [HOLD_W-1:0] LONG_THR_RESET  = 16'd3000;
    localparam logic [INC_W-1:0]  TICK_INC_RESET  = 8'd10;
    localparam logic              POLARITY_RESET  = 1'b0;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_THR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_THR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_INC  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POLARITY  = 2'd3;

    typedef struct packed {
        logic [HOLD_W-1:0] short_thr;
        logic [HOLD_W-1:0] long_thr;
        logic [INC_W-1:0]  tick_inc;
        logic              polarity;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_PRESS_DEB = 4'b0010,
        PH_PRESSED   = 4'b0100,
        PH_REL_DEB   = 4'b1000
    } phase_t;

endpackage

[rtl/kdpl_cfg.sv]
// ----------------------------------------------------------------------------
// kdpl_cfg
// Configuration register file: thresholds, tick increment and key polarity.
// ----------------------------------------------------------------------------
module kdpl_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [kdpl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [kdpl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output kdpl_pkg::cfg_t                   cfg
);
    import kdpl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_thr <= SHORT_THR_RESET;
            cfg_reg.long_thr  <= LONG_THR_RESET;
            cfg_reg.tick_inc  <= TICK_INC_RESET;
            cfg_reg.polarity  <= POLARITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SHORT_THR: cfg_reg.short_thr <= cfg_wdata[HOLD_W-1:0];
                REG_LONG_THR:  cfg_reg.long_thr  <= cfg_wdata[HOLD_W-1:0];
                REG_TICK_INC:  cfg_reg.tick_inc  <= cfg_wdata[INC_W-1:0];
                REG_POLARITY:  cfg_reg.polarity  <= cfg_wdata[0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/kdpl_key.sv]
// ----------------------------------------------------------------------------
// kdpl_key
// One key: four-phase debounce machine with a saturating hold timer.
// ----------------------------------------------------------------------------
module kdpl_key (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           level,
    input  kdpl_pkg::cfg_t cfg,
    output logic           short_ev,
    output logic           long_ev,
    output logic           busy
);
    import kdpl_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic [HOLD_W:0]   hold_sum;
    logic              pressed;

    assign pressed  = (level == cfg.polarity);
    assign hold_sum = {1'b0, hold_reg} + {{(HOLD_W + 1 - INC_W){1'b0}}, cfg.tick_inc};

    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        short_ev   = 1'b0;
        long_ev    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                    phase_next = PH_PRESS_DEB;
            end
            PH_PRESS_DEB:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESSED;
                    hold_next  = '0;
                end
                else
                    phase_next = PH_IDLE;
            end
            PH_PRESSED:
            begin
                if (pressed)
                    hold_next = hold_sum[HOLD_W] ? {HOLD_W{1'b1}} : hold_sum[HOLD_W-1:0];
                else
                    phase_next = PH_REL_DEB;
            end
            PH_REL_DEB:
            begin
                if (pressed)
                    phase_next = PH_PRESSED;
                else
                begin
                    phase_next = PH_IDLE;
                    hold_next  = '0;
                    // long test wins when the thresholds are crossed
                    if (hold_reg >= cfg.long_thr)
                        long_ev = 1'b1;
                    else if (hold_reg >= cfg.short_thr)
                        short_ev = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                hold_next  = '0;
            end
        endcase
    end

    assign busy = (phase_next != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

[rtl/key_debounce_press_length_classifier.sv]
// ----------------------------------------------------------------------------
// key_debounce_press_length_classifier
// Per-key debounce with short and long press classification.
// ----------------------------------------------------------------------------
// Each input word is one tick with the sampled level of every key; each tick
// gives exactly one result word with the short and long press events and the
// busy keys. A new word is taken every cycle while m_tready holds; the input
// register and the result register hold each tick, with the per-key state
// machines in between. The input register can still take the next tick while
// a finished result waits on m_tready. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata and should only change while no tick is in flight.
module key_debounce_press_length_classifier #(
    parameter int NUM_KEYS = kdpl_pkg::NUM_KEYS_DEF,
    localparam int IN_W    = ((NUM_KEYS + 7) / 8) * 8,
    localparam int OUT_W   = ((3 * NUM_KEYS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [kdpl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [kdpl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // key_levels
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata    // short_events, long_events, busy_keys
);
    import kdpl_pkg::*;

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [NUM_KEYS-1:0]   levels_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [3*NUM_KEYS-1:0] out_data_reg;
    logic                  advance;
    logic                  s_accept;
    logic [NUM_KEYS-1:0]   short_ev;
    logic [NUM_KEYS-1:0]   long_ev;
    logic [NUM_KEYS-1:0]   busy;

    kdpl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // tick moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kdpl_key u_key (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (advance),
            .level    (levels_reg[k]),
            .cfg      (cfg),
            .short_ev (short_ev[k]),
            .long_ev  (long_ev[k]),
            .busy     (busy[k])
        );
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            levels_reg <= s_tdata[NUM_KEYS-1:0];
        if (advance)
            out_data_reg <= {busy, long_ev, short_ev};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

[rtl/kdpl_checker.sv]
// ----------------------------------------------------------------------------
// kdpl_checker
// Port-level checks for the key debounce and press length classifier.
// ----------------------------------------------------------------------------
module kdpl_checker #(
    parameter int NUM_KEYS = kdpl_pkg::NUM_KEYS_DEF,
    localparam int IN_W    = ((NUM_KEYS + 7) / 8) * 8,
    localparam int OUT_W   = ((3 * NUM_KEYS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    logic [NUM_KEYS-1:0] shorts;
    logic [NUM_KEYS-1:0] longs;
    logic [NUM_KEYS-1:0] busys;

    assign shorts = m_tdata[NUM_KEYS-1:0];
    assign longs  = m_tdata[2*NUM_KEYS-1:NUM_KEYS];
    assign busys  = m_tdata[3*NUM_KEYS-1:2*NUM_KEYS];

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a release is either long or short, never both
    a_ev_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((shorts & longs) == '0))
        else $error("short and long event on the same key");

    // a key that just finished a press is idle
    a_ev_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (((shorts | longs) & busys) == '0))
        else $error("event on a key still busy");

    // a fresh result needs a tick taken through the input register first
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without an input word");

    // a waiting input word is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while stalled");

endmodule

bind key_debounce_press_length_classifier kdpl_checker #(.NUM_KEYS(NUM_KEYS)) u_kdpl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
